// ===== rtl/lru_page_replacement_top_macros.svh =====
// Assertion macros shared by the checkers of the page replacement block.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef LRU_PAGE_REPLACEMENT_TOP_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRU_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LRU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/lru_pkg.sv =====
package lru_pkg;

	// Built frame count and page width.
	localparam int NUM_FRAMES = 8;
	localparam int PAGE_BITS  = 16;

	// Derived widths: a slot index, and a count that can hold NUM_FRAMES itself.
	localparam int SLOT_W  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int CNT_W   = $clog2(NUM_FRAMES + 1);
	localparam int CFG_W   = 4;
	localparam int FAULT_W = 32;

	// Frame count register value after reset.
	localparam logic [CFG_W-1:0] RESET_FRAMES = CFG_W'(8);

	typedef logic [PAGE_BITS-1:0] page_t;
	typedef logic [SLOT_W-1:0]    slot_t;
	typedef logic [CNT_W-1:0]     count_t;
	typedef logic [SLOT_W-1:0]    rank_t;
	typedef logic [CFG_W-1:0]     cfg_t;
	typedef logic [FAULT_W-1:0]   fault_t;

	// Result of the parallel tag compare.
	typedef struct packed {
		logic  hit;
		slot_t slot;
	} lookup_t;

	// Where the referenced page ends up, and how it got there.
	typedef struct packed {
		logic  fill;
		logic  evict;
		slot_t slot;
	} place_t;

	// Usable frame count: zero counts as one, anything above the build is capped.
	function automatic count_t clamp_frames(input cfg_t v);
		count_t n;
		if (v == '0) begin
			n = count_t'(1);
		end else if (32'(v) > 32'(NUM_FRAMES)) begin
			n = count_t'(NUM_FRAMES);
		end else begin
			n = count_t'(v);
		end
		return n;
	endfunction

endpackage

// ===== rtl/lru_tag_store.sv =====
module lru_tag_store (
	input  logic             clk,
	input  lru_pkg::page_t   page,
	input  lru_pkg::count_t  usable,
	input  logic             wr_en,
	input  lru_pkg::place_t  place,
	output lru_pkg::lookup_t lookup,
	output lru_pkg::page_t   evicted_page
);
	import lru_pkg::*;

	// Resident page of each frame; only filled frames are ever read.
	page_t frame_page_q [NUM_FRAMES];

	// The referenced page goes into its slot on every fault.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			frame_page_q[place.slot] <= page;
		end
	end

	// Compare against every usable frame at once; the lowest matching slot wins.
	always_comb begin
		lookup = '0;
		for (int j = NUM_FRAMES - 1; j >= 0; j--) begin
			if ((32'(j) < 32'(usable)) && (frame_page_q[j] == page)) begin
				lookup.hit  = 1'b1;
				lookup.slot = SLOT_W'(j);
			end
		end
	end

	// The page being replaced, or zero when nothing is evicted.
	assign evicted_page = place.evict ? frame_page_q[place.slot] : '0;

endmodule

// ===== rtl/lru_rank_unit.sv =====
module lru_rank_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             upd,
	input  logic             clear,
	input  lru_pkg::count_t  frames,
	input  lru_pkg::lookup_t lookup,
	output lru_pkg::count_t  usable,
	output lru_pkg::place_t  place
);
	import lru_pkg::*;

	// Recency rank per frame (0 is most recent) and the number of filled frames.
	rank_t  rank_q [NUM_FRAMES];
	count_t filled_q;

	logic   full;
	slot_t  victim;
	rank_t  best_rank;
	rank_t  ref_rank;
	logic   age [NUM_FRAMES];

	// The store is full once the filled frames reach the usable count.
	assign full   = (filled_q >= frames);
	assign usable = full ? frames : filled_q;

	// Least recently used frame among the usable ones; the first maximum wins.
	always_comb begin
		victim    = '0;
		best_rank = rank_q[0];
		for (int j = 1; j < NUM_FRAMES; j++) begin
			if ((32'(j) < 32'(frames)) && (rank_q[j] > best_rank)) begin
				victim    = SLOT_W'(j);
				best_rank = rank_q[j];
			end
		end
	end

	// Choose the slot: the hit frame, the next empty frame, or the victim.
	always_comb begin
		place = '0;
		if (lookup.hit) begin
			place.slot = lookup.slot;
		end else if (!full) begin
			place.fill = 1'b1;
			place.slot = SLOT_W'(filled_q);
		end else begin
			place.evict = 1'b1;
			place.slot  = victim;
		end
	end

	// Filled frames more recent than the chosen one age by one; on a fill they all age.
	assign ref_rank = rank_q[place.slot];

	always_comb begin
		for (int j = 0; j < NUM_FRAMES; j++) begin
			age[j] = (32'(j) < 32'(filled_q)) && (place.fill || (rank_q[j] < ref_rank));
		end
	end

	// Rank and fill count update; the last reference of a string clears both.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
			for (int j = 0; j < NUM_FRAMES; j++) begin
				rank_q[j] <= '0;
			end
		end else if (upd) begin
			if (clear) begin
				filled_q <= '0;
				for (int j = 0; j < NUM_FRAMES; j++) begin
					rank_q[j] <= '0;
				end
			end else begin
				if (place.fill) begin
					filled_q <= filled_q + count_t'(1);
				end
				for (int j = 0; j < NUM_FRAMES; j++) begin
					if (SLOT_W'(j) == place.slot) begin
						rank_q[j] <= '0;
					end else if (age[j]) begin
						rank_q[j] <= rank_q[j] + rank_t'(1);
					end
				end
			end
		end
	end

endmodule

// ===== rtl/lru_page_replacement_top.sv =====
// Channel   Handshake              Carries
// input     start, busy            page, last_ref
// result    done (strobe)          hit, frame_slot, evicted_valid, evicted_page,
//                                  fault_total, last_out
// config    cfg_valid, cfg_ready   cfg_data (frames in use)
//
// One reference is taken per cycle; busy stays low.
// A result passes the input register and the result register after its reference is accepted, for one cycle.
// The rate is set by the rank and fill update, which completes in the cycle that
// registers the result, so the next reference always sees the updated store.
// Reset clears the ranks, fill count, fault count and pipeline valids at once.
// The receiver cannot stall results, so none are ever held back.
module lru_page_replacement_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  lru_pkg::page_t  page,
	input  logic            last_ref,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  lru_pkg::cfg_t   cfg_data,
	output logic            done,
	output logic            hit,
	output lru_pkg::slot_t  frame_slot,
	output logic            evicted_valid,
	output lru_pkg::page_t  evicted_page,
	output lru_pkg::fault_t fault_total,
	output logic            last_out
);
	import lru_pkg::*;

	cfg_t    frames_in_use_q;
	count_t  frames;
	logic    valid_s1;
	page_t   page_s1;
	logic    last_s1;
	count_t  usable;
	lookup_t lookup;
	place_t  place;
	page_t   ev_page;
	fault_t  fault_q;
	fault_t  fault_new;

	logic    done_q;
	logic    hit_q;
	slot_t   slot_q;
	logic    ev_valid_q;
	page_t   ev_page_q;
	fault_t  fault_total_q;
	logic    last_q;

	// Every reference and every configuration transfer is taken at once.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Frame count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= RESET_FRAMES;
		end else if (cfg_valid && cfg_ready) begin
			frames_in_use_q <= cfg_data;
		end
	end

	assign frames = clamp_frames(frames_in_use_q);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			page_s1 <= page;
			last_s1 <= last_ref;
		end
	end

	lru_tag_store u_tag_store (
		.clk          (clk),
		.page         (page_s1),
		.usable       (usable),
		.wr_en        (valid_s1 && !lookup.hit),
		.place        (place),
		.lookup       (lookup),
		.evicted_page (ev_page)
	);

	lru_rank_unit u_rank_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (valid_s1),
		.clear  (last_s1),
		.frames (frames),
		.lookup (lookup),
		.usable (usable),
		.place  (place)
	);

	// Fault count saturates at all ones and clears after the last reference.
	assign fault_new = (!lookup.hit && (fault_q != '1)) ? fault_q + fault_t'(1) : fault_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_q <= '0;
		end else if (valid_s1) begin
			fault_q <= last_s1 ? '0 : fault_new;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			hit_q         <= lookup.hit;
			slot_q        <= place.slot;
			ev_valid_q    <= place.evict;
			ev_page_q     <= ev_page;
			fault_total_q <= fault_new;
			last_q        <= last_s1;
		end
	end

	assign done          = done_q;
	assign hit           = hit_q;
	assign frame_slot    = slot_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_page  = ev_page_q;
	assign fault_total   = fault_total_q;
	assign last_out      = last_q;

endmodule

// ===== rtl/lru_page_replacement_chk.sv =====
`include "lru_page_replacement_top_macros.svh"

module lru_page_replacement_chk (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input logic            done,
	input logic            hit,
	input logic            evicted_valid,
	input lru_pkg::page_t  evicted_page,
	input lru_pkg::fault_t fault_total,
	input logic            last_out
);

	// Every accepted reference gives its result after the input and result registers.
	`LRU_ASSERT_SAME(a_result_follows, start && !busy, ##2 done, "accepted reference gave no result")

	// No result appears without a reference accepted ahead of it through the input and result registers.
	`LRU_ASSERT_SAME(a_no_spurious, done, $past(start && !busy, 2), "result without reference")

	// A fault always leaves a non-zero fault total.
	`LRU_ASSERT_SAME(a_fault_counted, done && !hit, fault_total != '0, "fault not counted")

	// A hit never evicts a page.
	`LRU_ASSERT_SAME(a_hit_no_evict, done && hit, !evicted_valid && (evicted_page == '0),
		"hit reported an eviction")

	// A hit straight after a result of the same string leaves the fault total unchanged.
	`LRU_ASSERT_NEXT(a_hit_keeps_total, done && !last_out, !(done && hit) || $stable(fault_total),
		"hit changed the fault total")

endmodule

bind lru_page_replacement_top lru_page_replacement_chk u_chk (.*);
